// ===== rtl/core/ledscan_pkg.sv =====
// Shared types and constants for the LED matrix scan framebuffer.
package ledscan_pkg;

  // Field widths of the command and result transactions
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ColXW  = 4;
  localparam int unsigned RowYW  = 3;
  localparam int unsigned PixW   = 8;
  localparam int unsigned BitsW  = 8;

  typedef enum logic [CmdW-1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdClear = 2'd2,
    CmdScan  = 2'd3
  } cmd_e;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [BitsW-1:0] bits_t;

endpackage

// ===== rtl/core/ledscan_if.sv =====
// Command and result channel interfaces of the LED matrix scan framebuffer.
interface ledscan_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [ledscan_pkg::CmdW-1:0]     command;
  logic [ledscan_pkg::ColXW-1:0]    col_x;
  logic [ledscan_pkg::RowYW-1:0]    row_y;
  logic [ledscan_pkg::PixW-1:0]     pixel_level;

  modport source (output valid, command, col_x, row_y, pixel_level, input ready);
  modport sink   (input valid, command, col_x, row_y, pixel_level, output ready);
endinterface

interface ledscan_res_if;
  logic                          valid;
  logic                          ready;
  logic [ledscan_pkg::PixW-1:0]  read_data;
  logic                          frame_valid;
  logic [ledscan_pkg::BitsW-1:0] left_columns;
  logic [ledscan_pkg::BitsW-1:0] row_select;
  logic [ledscan_pkg::BitsW-1:0] right_columns;
  logic                          frame_end;

  modport source (output valid, read_data, frame_valid, left_columns, row_select,
                  right_columns, frame_end, input ready);
  modport sink   (input valid, read_data, frame_valid, left_columns, row_select,
                  right_columns, frame_end, output ready);
endinterface

// ===== rtl/core/led_matrix_pwm_scan_framebuffer.sv =====
// Top level: row-organized pixel memory with read-modify-write and PWM row scanner.
//
//  channel | dir | payload                                              | handshake
//  cmd_i   | in  | command, col_x, row_y, pixel_level                   | valid/ready
//  res_o   | out | read_data, frame_valid, left_columns, row_select,    | valid/ready
//          |     | right_columns, frame_end                             |
//
// Each command first reads the addressed row of the pixel memory (one full row per
// entry, synchronous read), then compares, merges and writes back.
// A clear drops the per-row valid bits; an invalid row reads as zero.
// Reset clears the row valid bits and the scan row and level counters at once.
// A stalled result holds in the output register; a new command is taken while it
// waits, and that command's compare and write-back step waits for the output register to free up.
module led_matrix_pwm_scan_framebuffer #(
  parameter int unsigned COLS_PER_MATRIX = 8,
  parameter int unsigned ROWS            = 8,
  parameter int unsigned LEVELS          = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ledscan_cmd_if.sink   cmd_i,
  ledscan_res_if.source res_o
);

  localparam int unsigned LinePix = 2 * COLS_PER_MATRIX;
  localparam int unsigned ColAw   = $clog2(LinePix);
  localparam int unsigned RowAw   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LvW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef logic [LinePix-1:0][ledscan_pkg::PixW-1:0] row_t;

  // Control state
  logic                busy_q;
  logic                out_valid_q;
  logic [ROWS-1:0]     row_valid_q;
  logic [RowAw-1:0]    scan_row_q, scan_row_d;
  logic [LvW-1:0]      scan_level_q, scan_level_d;

  // Captured command
  ledscan_pkg::cmd_e   cmd_q;
  logic [ColAw-1:0]    col_q;
  logic [RowAw-1:0]    row_q;
  logic                addr_ok_q;
  ledscan_pkg::pix_t   pix_q;

  // Pixel memory, one row per entry
  row_t                mem [ROWS];
  row_t                rd_data_q;
  logic                rd_valid_q;
  logic [RowAw-1:0]    rd_addr;

  // Result register
  ledscan_pkg::pix_t   read_data_q, read_data_d;
  logic                frame_valid_q, frame_valid_d;
  ledscan_pkg::bits_t  left_q, left_d;
  ledscan_pkg::bits_t  rsel_q, rsel_d;
  ledscan_pkg::bits_t  right_q, right_d;
  logic                frame_end_q, frame_end_d;

  logic                cmd_acc;
  logic                fin;
  logic                addr_ok;
  logic                wr_en;
  row_t                row_word;
  row_t                wr_word;
  logic [LinePix-1:0]  hit;

  assign cmd_i.ready = !busy_q;
  assign cmd_acc     = cmd_i.valid && !busy_q;
  assign fin         = busy_q && (!out_valid_q || res_o.ready);

  // Address check and read address of the accepted command
  assign addr_ok = (5'(cmd_i.col_x) < 5'(LinePix)) && (4'(cmd_i.row_y) < 4'(ROWS));
  assign rd_addr = (ledscan_pkg::cmd_e'(cmd_i.command) == ledscan_pkg::CmdScan) ?
                   scan_row_q : cmd_i.row_y[RowAw-1:0];

  // Memory read port and write port
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      rd_data_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[row_q] <= wr_word;
    end
  end

  // Row data as stored, zero for rows not written since reset or clear
  assign row_word = rd_valid_q ? rd_data_q : '0;

  // Pixel merge for a write
  always_comb begin
    wr_word        = row_word;
    wr_word[col_q] = pix_q;
  end

  assign wr_en = fin && (cmd_q == ledscan_pkg::CmdWrite) && addr_ok_q;

  // PWM compare across the whole row
  always_comb begin
    for (int unsigned c = 0; c < LinePix; c++) begin
      hit[c] = row_word[c] > ledscan_pkg::PixW'(scan_level_q);
    end
  end

  // Result and counter update
  always_comb begin
    read_data_d   = '0;
    frame_valid_d = 1'b0;
    left_d        = '0;
    rsel_d        = '0;
    right_d       = '0;
    frame_end_d   = 1'b0;
    scan_row_d    = scan_row_q;
    scan_level_d  = scan_level_q;
    unique case (cmd_q)
      ledscan_pkg::CmdWrite: begin
      end
      ledscan_pkg::CmdRead: begin
        if (addr_ok_q) begin
          read_data_d = row_word[col_q];
        end
      end
      ledscan_pkg::CmdClear: begin
      end
      ledscan_pkg::CmdScan: begin
        frame_valid_d = 1'b1;
        for (int unsigned j = 0; j < COLS_PER_MATRIX; j++) begin
          left_d[j]  = hit[j];
          right_d[j] = hit[COLS_PER_MATRIX + j];
        end
        rsel_d      = ledscan_pkg::BitsW'(1) << scan_row_q;
        frame_end_d = (scan_row_q == RowAw'(ROWS - 1)) && (scan_level_q == LvW'(LEVELS - 1));
        if (scan_row_q == RowAw'(ROWS - 1)) begin
          scan_row_d   = '0;
          scan_level_d = (scan_level_q == LvW'(LEVELS - 1)) ? '0 : scan_level_q + 1'b1;
        end else begin
          scan_row_d = scan_row_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      row_valid_q  <= '0;
      scan_row_q   <= '0;
      scan_level_q <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (cmd_acc) begin
        busy_q     <= 1'b1;
        rd_valid_q <= row_valid_q[rd_addr];
      end else if (fin) begin
        busy_q <= 1'b0;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fin && (cmd_q == ledscan_pkg::CmdClear)) begin
        row_valid_q <= '0;
      end else if (wr_en) begin
        row_valid_q[row_q] <= 1'b1;
      end
      if (fin) begin
        scan_row_q   <= scan_row_d;
        scan_level_q <= scan_level_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      cmd_q     <= ledscan_pkg::cmd_e'(cmd_i.command);
      col_q     <= cmd_i.col_x[ColAw-1:0];
      row_q     <= cmd_i.row_y[RowAw-1:0];
      addr_ok_q <= addr_ok;
      pix_q     <= cmd_i.pixel_level;
    end
    if (fin) begin
      read_data_q   <= read_data_d;
      frame_valid_q <= frame_valid_d;
      left_q        <= left_d;
      rsel_q        <= rsel_d;
      right_q       <= right_d;
      frame_end_q   <= frame_end_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.read_data     = read_data_q;
  assign res_o.frame_valid   = frame_valid_q;
  assign res_o.left_columns  = left_q;
  assign res_o.row_select    = rsel_q;
  assign res_o.right_columns = right_q;
  assign res_o.frame_end     = frame_end_q;

endmodule

// ===== rtl/core/ledscan_checker.sv =====
// Port-level checks for the LED matrix scan framebuffer, bound to the top level.
module ledscan_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] read_data_i,
  input logic       frame_valid_i,
  input logic [7:0] left_columns_i,
  input logic [7:0] row_select_i,
  input logic [7:0] right_columns_i,
  input logic       frame_end_i
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = cmd_valid_i && cmd_ready_i;
  assign out_acc = res_valid_i && res_ready_i;
  assign pend_d  = pend_q + 2'(in_acc) - 2'(out_acc);

  // Commands accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Every result answers an accepted command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pend_q != 2'd0)
    else $error("result without an outstanding command");

  // A scan frame drives exactly one row and no read data
  a_frame_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && frame_valid_i) |-> ($onehot(row_select_i) && read_data_i == 8'd0))
    else $error("scan frame with bad row select or read data");

  // Non-scan results carry no frame bits
  a_noframe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !frame_valid_i) |->
      (row_select_i == 8'd0 && left_columns_i == 8'd0 &&
       right_columns_i == 8'd0 && !frame_end_i))
    else $error("frame bits on a non-scan result");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(read_data_i) && $stable(frame_valid_i) &&
       $stable(left_columns_i) && $stable(row_select_i) &&
       $stable(right_columns_i) && $stable(frame_end_i)))
    else $error("stalled result changed");

endmodule

bind led_matrix_pwm_scan_framebuffer ledscan_checker u_ledscan_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cmd_valid_i     (cmd_i.valid),
  .cmd_ready_i     (cmd_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .read_data_i     (res_o.read_data),
  .frame_valid_i   (res_o.frame_valid),
  .left_columns_i  (res_o.left_columns),
  .row_select_i    (res_o.row_select),
  .right_columns_i (res_o.right_columns),
  .frame_end_i     (res_o.frame_end)
);
